[sv/cau_pkg.sv]
`timescale 1ns / 1ps
// Shared types, widths and saturation helpers for the complex arithmetic unit.
package cau_pkg;

   localparam int DATA_WIDTH = 16;
   localparam int FRAC_BITS  = 8;

   localparam int DW     = DATA_WIDTH;
   localparam int PW     = 2 * DW;                    // product width
   localparam int SUM_W  = PW + 1;                    // sum of two products
   localparam int QB     = DW;                        // quotient bits below the overflow bit
   localparam int RW     = PW + ((FRAC_BITS > QB) ? FRAC_BITS : QB);  // divider datapath
   localparam int DIV_STEPS = QB + 1;                 // overflow step plus one per quotient bit

   typedef enum logic [1:0] {
      CMD_ADD = 2'd0,
      CMD_SUB = 2'd1,
      CMD_MUL = 2'd2,
      CMD_DIV = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      STATUS_OK   = 2'd0,
      STATUS_SAT  = 2'd1,
      STATUS_DIVZ = 2'd2
   } status_type;

   typedef struct packed {
      cmd_type                cmd;
      logic signed [DW-1:0]   a_real;
      logic signed [DW-1:0]   a_imag;
      logic signed [DW-1:0]   b_real;
      logic signed [DW-1:0]   b_imag;
   } req_type;

   typedef struct packed {
      logic signed [DW-1:0]   res_real;
      logic signed [DW-1:0]   res_imag;
      status_type             status;
   } rsp_type;

   typedef struct packed {
      logic signed [DW-1:0]   value;
      logic                   flag;
   } sat_type;

   // Front end result: exact lane sums and the divisor magnitude.
   typedef struct packed {
      cmd_type                  cmd;
      logic signed [SUM_W-1:0]  sum_re;
      logic signed [SUM_W-1:0]  sum_im;
      logic [PW-1:0]            den;
   } front_type;

   // Item state inside the divider chain.
   typedef struct packed {
      logic                   is_div;
      logic                   neg_re;
      logic                   neg_im;
      logic [RW-1:0]          ds;
      logic [RW-1:0]          r_re;
      logic [RW-1:0]          r_im;
      logic [QB:0]            q_re;
      logic [QB:0]            q_im;
      rsp_type                res;
   } div_type;

   localparam logic signed [DW-1:0]    RES_MAX = {1'b0, {(DW-1){1'b1}}};
   localparam logic signed [DW-1:0]    RES_MIN = {1'b1, {(DW-1){1'b0}}};
   localparam logic signed [SUM_W-1:0] SUM_MAX = {{(SUM_W-DW){1'b0}}, RES_MAX};
   localparam logic signed [SUM_W-1:0] SUM_MIN = {{(SUM_W-DW){1'b1}}, RES_MIN};
   localparam logic [QB:0]             MAG_POS = {2'b00, {(DW-1){1'b1}}};
   localparam logic [QB:0]             MAG_NEG = {2'b01, {(DW-1){1'b0}}};

   // Clamp an exact signed sum to the result range.
   function automatic sat_type sat_sum(input logic signed [SUM_W-1:0] v);
      sat_type s;
      if (v > SUM_MAX) begin
         s.value = RES_MAX;
         s.flag  = 1'b1;
      end else if (v < SUM_MIN) begin
         s.value = RES_MIN;
         s.flag  = 1'b1;
      end else begin
         s.value = v[DW-1:0];
         s.flag  = 1'b0;
      end
      return s;
   endfunction

   // Clamp a sign and quotient magnitude; the top bit means the quotient overflowed.
   function automatic sat_type sat_mag(input logic neg, input logic [QB:0] mag);
      sat_type s;
      if (neg) begin
         if (mag > MAG_NEG) begin
            s.value = RES_MIN;
            s.flag  = 1'b1;
         end else begin
            s.value = -mag[DW-1:0];
            s.flag  = 1'b0;
         end
      end else begin
         if (mag > MAG_POS) begin
            s.value = RES_MAX;
            s.flag  = 1'b1;
         end else begin
            s.value = mag[DW-1:0];
            s.flag  = 1'b0;
         end
      end
      return s;
   endfunction

endpackage

[sv/complex_arithmetic_unit.sv]
`timescale 1ns / 1ps
// Top level of the complex arithmetic unit: add, subtract, multiply, divide in Q8.8.
//
// Usage:
//   Drive req_data (cmd and both complex operands) and raise start. The item is
//   taken at any rising edge with start high and busy low. busy never asserts,
//   so a new item may enter on every clock cycle.
//   Each item gives exactly one result: rsp_valid is high for one cycle with
//   rsp_data holding res_real, res_imag and status (ok, saturated, divide by zero).
//   Latency is the same for every command: two front-end stages
//   (products, then lane sums), one setup stage, one divider step per quotient
//   bit plus an overflow step (17 stages), and one output stage. The divider
//   step, a 48-bit compare and subtract, sets the stage depth. Because all
//   commands share the same latency, results leave in arrival order.
//   Throughput is one item per cycle.
//   Synchronous reset drops all items in flight; the block is ready right after.
//   The receiver cannot hold results off, so the pipeline never stalls.
module complex_arithmetic_unit
   import cau_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     start,
   output logic     busy,
   input  req_type  req_data,
   output logic     rsp_valid,
   output rsp_type  rsp_data
);

   logic       in_accept;
   logic       front_valid;
   front_type  front_data;

   logic       prep_valid_ff;
   div_type    prep_data_ff;
   div_type    prep_data_in;

   logic       step_valid [DIV_STEPS+1];
   div_type    step_data  [DIV_STEPS+1];

   logic       rsp_valid_ff;
   rsp_type    rsp_data_ff;
   rsp_type    rsp_data_in;

   // Prep-stage scratch
   logic signed [SUM_W-1:0] shr_re, shr_im;
   logic [SUM_W-1:0]        mag_re, mag_im;
   sat_type                 s_re, s_im;
   sat_type                 d_re, d_im;
   div_type                 last;

   // The pipeline never backs up, so accept every start.
   assign busy      = 1'b0;
   assign in_accept = start & ~busy;

   cau_front u_front (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (in_accept),
      .in_data      (req_data),
      .out_valid_ff (front_valid),
      .out_data_ff  (front_data)
   );

   // Setup stage: finish add, subtract and multiply here; load the divider
   // with magnitudes for a divide, or post the divide-by-zero answer.
   always_comb begin
      shr_re = front_data.sum_re >>> FRAC_BITS;     // floor shift
      shr_im = front_data.sum_im >>> FRAC_BITS;
      mag_re = front_data.sum_re[SUM_W-1] ? SUM_W'(-front_data.sum_re)
                                          : SUM_W'(front_data.sum_re);
      mag_im = front_data.sum_im[SUM_W-1] ? SUM_W'(-front_data.sum_im)
                                          : SUM_W'(front_data.sum_im);

      if (front_data.cmd == CMD_MUL) begin
         s_re = sat_sum(shr_re);
         s_im = sat_sum(shr_im);
      end else begin
         s_re = sat_sum(front_data.sum_re);
         s_im = sat_sum(front_data.sum_im);
      end

      prep_data_in.is_div       = 1'b0;
      prep_data_in.neg_re       = front_data.sum_re[SUM_W-1];
      prep_data_in.neg_im       = front_data.sum_im[SUM_W-1];
      // Shifted divisor starts at the overflow position.
      prep_data_in.ds           = RW'(front_data.den) << QB;
      prep_data_in.r_re         = RW'(mag_re[PW-1:0]) << FRAC_BITS;
      prep_data_in.r_im         = RW'(mag_im[PW-1:0]) << FRAC_BITS;
      prep_data_in.q_re         = '0;
      prep_data_in.q_im         = '0;
      prep_data_in.res.res_real = s_re.value;
      prep_data_in.res.res_imag = s_im.value;
      prep_data_in.res.status   = (s_re.flag | s_im.flag) ? STATUS_SAT : STATUS_OK;

      if (front_data.cmd == CMD_DIV) begin
         if (front_data.den == '0) begin
            prep_data_in.res.res_real = '0;
            prep_data_in.res.res_imag = '0;
            prep_data_in.res.status   = STATUS_DIVZ;
         end else begin
            prep_data_in.is_div = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prep_valid_ff <= 1'b0;
      end else begin
         prep_valid_ff <= front_valid;
      end
   end

   always_ff @(posedge clock) begin
      prep_data_ff <= prep_data_in;
   end

   // Divider chain: every item walks it, so latency is the same for all commands.
   assign step_valid[0] = prep_valid_ff;
   assign step_data[0]  = prep_data_ff;

   for (genvar g = 0; g < DIV_STEPS; g++) begin : g_div
      cau_div_step u_step (
         .clock        (clock),
         .reset        (reset),
         .in_valid     (step_valid[g]),
         .in_data      (step_data[g]),
         .out_valid_ff (step_valid[g+1]),
         .out_data_ff  (step_data[g+1])
      );
   end

   // Output stage: clamp the quotients of a divide, pass everything else.
   always_comb begin
      last = step_data[DIV_STEPS];
      d_re = sat_mag(last.neg_re, last.q_re);
      d_im = sat_mag(last.neg_im, last.q_im);
      if (last.is_div) begin
         rsp_data_in.res_real = d_re.value;
         rsp_data_in.res_imag = d_im.value;
         rsp_data_in.status   = (d_re.flag | d_im.flag) ? STATUS_SAT : STATUS_OK;
      end else begin
         rsp_data_in = last.res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= step_valid[DIV_STEPS];
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

[sv/cau_front.sv]
`timescale 1ns / 1ps
// Front end: operand products, then the exact lane sums and divisor magnitude.
module cau_front
   import cau_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       in_valid,
   input  req_type    in_data,
   output logic       out_valid_ff,
   output front_type  out_data_ff
);

   logic                  p_valid_ff;
   req_type               op_ff;
   logic signed [PW-1:0]  p_rr_ff;   // a_real * b_real
   logic signed [PW-1:0]  p_ii_ff;   // a_imag * b_imag
   logic signed [PW-1:0]  p_ri_ff;   // a_real * b_imag
   logic signed [PW-1:0]  p_ir_ff;   // a_imag * b_real
   logic signed [PW-1:0]  p_bb_r_ff;
   logic signed [PW-1:0]  p_bb_i_ff;

   logic signed [SUM_W-1:0] re_x, re_y, im_x, im_y;
   logic                    re_sub, im_sub;
   front_type               out_data_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         p_valid_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         p_valid_ff   <= in_valid;
         out_valid_ff <= p_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= in_data;
      p_rr_ff     <= in_data.a_real * in_data.b_real;
      p_ii_ff     <= in_data.a_imag * in_data.b_imag;
      p_ri_ff     <= in_data.a_real * in_data.b_imag;
      p_ir_ff     <= in_data.a_imag * in_data.b_real;
      p_bb_r_ff   <= in_data.b_real * in_data.b_real;
      p_bb_i_ff   <= in_data.b_imag * in_data.b_imag;
      out_data_ff <= out_data_in;
   end

   // Pick the operands of each lane adder by command.
   always_comb begin
      re_x   = {{(SUM_W-DW){op_ff.a_real[DW-1]}}, op_ff.a_real};
      re_y   = {{(SUM_W-DW){op_ff.b_real[DW-1]}}, op_ff.b_real};
      im_x   = {{(SUM_W-DW){op_ff.a_imag[DW-1]}}, op_ff.a_imag};
      im_y   = {{(SUM_W-DW){op_ff.b_imag[DW-1]}}, op_ff.b_imag};
      re_sub = 1'b0;
      im_sub = 1'b0;
      unique case (op_ff.cmd)
         CMD_ADD: begin
         end
         CMD_SUB: begin
            re_sub = 1'b1;
            im_sub = 1'b1;
         end
         CMD_MUL: begin
            re_x   = {{(SUM_W-PW){p_rr_ff[PW-1]}}, p_rr_ff};
            re_y   = {{(SUM_W-PW){p_ii_ff[PW-1]}}, p_ii_ff};
            im_x   = {{(SUM_W-PW){p_ri_ff[PW-1]}}, p_ri_ff};
            im_y   = {{(SUM_W-PW){p_ir_ff[PW-1]}}, p_ir_ff};
            re_sub = 1'b1;
         end
         CMD_DIV: begin
            re_x   = {{(SUM_W-PW){p_rr_ff[PW-1]}}, p_rr_ff};
            re_y   = {{(SUM_W-PW){p_ii_ff[PW-1]}}, p_ii_ff};
            im_x   = {{(SUM_W-PW){p_ir_ff[PW-1]}}, p_ir_ff};
            im_y   = {{(SUM_W-PW){p_ri_ff[PW-1]}}, p_ri_ff};
            im_sub = 1'b1;
         end
         default: begin
         end
      endcase

      out_data_in.cmd    = op_ff.cmd;
      out_data_in.sum_re = re_sub ? (re_x - re_y) : (re_x + re_y);
      out_data_in.sum_im = im_sub ? (im_x - im_y) : (im_x + im_y);
      // Both squares are non-negative, so their unsigned sum fits.
      out_data_in.den    = PW'(p_bb_r_ff) + PW'(p_bb_i_ff);
   end

endmodule

[sv/cau_div_step.sv]
`timescale 1ns / 1ps
// One restoring-division step for both lanes, registered.
module cau_div_step
   import cau_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   input  div_type  in_data,
   output logic     out_valid_ff,
   output div_type  out_data_ff
);

   div_type out_data_in;
   logic    take_re, take_im;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff <= out_data_in;
   end

   always_comb begin
      take_re          = (in_data.r_re >= in_data.ds);
      take_im          = (in_data.r_im >= in_data.ds);
      out_data_in      = in_data;
      out_data_in.r_re = take_re ? (in_data.r_re - in_data.ds) : in_data.r_re;
      out_data_in.r_im = take_im ? (in_data.r_im - in_data.ds) : in_data.r_im;
      out_data_in.q_re = {in_data.q_re[QB-1:0], take_re};
      out_data_in.q_im = {in_data.q_im[QB-1:0], take_im};
      out_data_in.ds   = in_data.ds >> 1;
   end

endmodule

[tb/sv/complex_arithmetic_unit_tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the complex arithmetic unit: directed corners plus random items.
module complex_arithmetic_unit_tb;
   import cau_pkg::*;

   // Latency from the head of the block, with margin for the drain at the end.
   localparam int PIPE_LATENCY = 21;
   localparam int DRAIN_CYCLES = 2 * PIPE_LATENCY;
   localparam int RANDOM_ITEMS = 2000;

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_data;
   logic    rsp_valid;
   rsp_type rsp_data;

   // Predicted results, oldest first; the block keeps arrival order.
   rsp_type complex_answers[$];
   int      error_count;
   int      steady_items;   // items left in a back-to-back stretch

   complex_arithmetic_unit dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   always begin
      clock = 1'b1;
      #6;
      clock = 1'b0;
      #6;
   end

   // Clamp one exact part to the signed result range and flag the clip.
   function automatic logic signed [DW-1:0] clamp_part(input longint v, inout logic hit);
      longint hi;
      longint lo;
      hi = (longint'(1) <<< (DW - 1)) - 1;
      lo = -(longint'(1) <<< (DW - 1));
      if (v > hi) begin
         hit = 1'b1;
         return hi[DW-1:0];
      end
      if (v < lo) begin
         hit = 1'b1;
         return lo[DW-1:0];
      end
      return v[DW-1:0];
   endfunction

   // Work out the exact complex result of one item, then saturate each part.
   function automatic rsp_type predict_complex(input req_type r);
      longint  ar, ai, br, bi;
      longint  re, im, den, scale;
      logic    hit;
      rsp_type p;
      ar    = longint'($signed(r.a_real));
      ai    = longint'($signed(r.a_imag));
      br    = longint'($signed(r.b_real));
      bi    = longint'($signed(r.b_imag));
      scale = longint'(1) <<< FRAC_BITS;
      re    = 0;
      im    = 0;
      case (r.cmd)
         CMD_ADD: begin
            re = ar + br;
            im = ai + bi;
         end
         CMD_SUB: begin
            re = ar - br;
            im = ai - bi;
         end
         CMD_MUL: begin
            // arithmetic shift floors toward minus infinity
            re = (ar * br - ai * bi) >>> FRAC_BITS;
            im = (ar * bi + ai * br) >>> FRAC_BITS;
         end
         default: begin
            den = br * br + bi * bi;
            if (den == 0) begin
               p.res_real = '0;
               p.res_imag = '0;
               p.status   = STATUS_DIVZ;
               return p;
            end
            // signed division truncates toward zero
            re = ((ar * br + ai * bi) * scale) / den;
            im = ((ai * br - ar * bi) * scale) / den;
         end
      endcase
      hit        = 1'b0;
      p.res_real = clamp_part(re, hit);
      p.res_imag = clamp_part(im, hit);
      p.status   = hit ? STATUS_SAT : STATUS_OK;
      return p;
   endfunction

   function automatic req_type make_req(input cmd_type op, input int ar, input int ai,
                                        input int br, input int bi);
      req_type r;
      r.cmd    = op;
      r.a_real = ar[DW-1:0];
      r.a_imag = ai[DW-1:0];
      r.b_real = br[DW-1:0];
      r.b_imag = bi[DW-1:0];
      return r;
   endfunction

   // Mostly back-to-back or short gaps, a few long ones, and bursts with none.
   function automatic int pick_gap();
      int roll;
      if (steady_items > 0) begin
         steady_items--;
         return 0;
      end
      roll = $urandom_range(0, 99);
      if (roll < 3) begin
         steady_items = $urandom_range(20, 80);
         return 0;
      end
      if (roll < 55) return 0;
      if (roll < 88) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 40);
   endfunction

   // Operand mix: full range for bit coverage, small values for unclipped
   // products, and the usual boundary values.
   function automatic int pick_operand();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 35) return $urandom_range(0, 65535);
      if (roll < 65) return int'($urandom_range(0, 2047)) - 1024;
      if (roll < 85) return int'($urandom_range(0, 16383)) - 8192;
      case ($urandom_range(0, 6))
         0:       return -32768;
         1:       return -32767;
         2:       return -1;
         3:       return 0;
         4:       return 1;
         5:       return 32766;
         default: return 32767;
      endcase
   endfunction

   // Present one item, hold it until taken, then idle for a random gap.
   // With no gap the next item is driven at the very edge that took this one.
   task automatic send_item(input req_type item);
      int gap;
      start    <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (busy);
      gap = pick_gap();
      if (gap > 0) begin
         start <= 1'b0;
         // drive junk while idle; the block must ignore it
         req_data <= req_type'({$urandom, $urandom, $urandom});
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic test_add_sub();
      send_item(make_req(CMD_ADD, 32767, 32767, 32767, 32767));
      send_item(make_req(CMD_ADD, -32768, -32768, -32768, -32768));
      send_item(make_req(CMD_ADD, -32768, 32767, 32767, -32768));
      send_item(make_req(CMD_ADD, 0, 0, 0, 0));
      send_item(make_req(CMD_SUB, -32768, 32767, 32767, -32768));
      send_item(make_req(CMD_SUB, 32767, -1, 32767, 1));
      send_item(make_req(CMD_SUB, -1, 0, 1, -32768));
   endtask

   task automatic test_multiply();
      send_item(make_req(CMD_MUL, -32768, -32768, -32768, -32768));
      send_item(make_req(CMD_MUL, 256, 0, 256, 0));
      // tiny negative product must floor to -1, not truncate to 0
      send_item(make_req(CMD_MUL, -1, 0, 1, 0));
      send_item(make_req(CMD_MUL, 32767, 32767, 32767, 32767));
      send_item(make_req(CMD_MUL, 32767, -32768, -32768, 32767));
      send_item(make_req(CMD_MUL, 384, -128, -640, 512));
   endtask

   task automatic test_divide();
      // zero divisor with nonzero and zero numerators, then a nonzero divisor
      send_item(make_req(CMD_DIV, 256, -256, 0, 0));
      send_item(make_req(CMD_DIV, 0, 0, 0, 0));
      send_item(make_req(CMD_DIV, 1, 0, 1, 0));
      // negative quotient truncates toward zero
      send_item(make_req(CMD_DIV, -1, 0, 3, 0));
      send_item(make_req(CMD_DIV, -1, 0, 256, 0));
      send_item(make_req(CMD_DIV, 32767, 32767, 1, 1));
      send_item(make_req(CMD_DIV, -32768, -32768, -32768, -32768));
      send_item(make_req(CMD_DIV, 100, -50, 0, -1));
      send_item(make_req(CMD_DIV, -32768, 32767, 32767, -32768));
   endtask

   task automatic test_random();
      req_type r;
      int      roll;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         r = make_req(cmd_type'($urandom_range(0, 3)), pick_operand(), pick_operand(),
                      pick_operand(), pick_operand());
         if (r.cmd == CMD_DIV) begin
            roll = $urandom_range(0, 99);
            if (roll < 5) begin
               r.b_real = '0;
               r.b_imag = '0;
            end else if (roll < 10) begin
               r.b_real = '0;
            end else if (roll < 15) begin
               r.b_imag = '0;
            end
         end
         send_item(r);
      end
   endtask

   // Record the prediction for every item the block takes.
   always @(posedge clock) begin
      if (!reset && start && !busy)
         complex_answers.push_back(predict_complex(req_data));
   end

   // Compare each result with the oldest prediction, field by field.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid) begin
         if (complex_answers.size() == 0) begin
            $display("%0t: unexpected result re=%0d im=%0d status=%s", $time,
                     rsp_data.res_real, rsp_data.res_imag, rsp_data.status.name());
            error_count++;
         end else begin
            want = complex_answers.pop_front();
            if (rsp_data.res_real !== want.res_real) begin
               $display("%0t: res_real expected %0d actual %0d", $time,
                        want.res_real, rsp_data.res_real);
               error_count++;
            end
            if (rsp_data.res_imag !== want.res_imag) begin
               $display("%0t: res_imag expected %0d actual %0d", $time,
                        want.res_imag, rsp_data.res_imag);
               error_count++;
            end
            if (rsp_data.status !== want.status) begin
               $display("%0t: status expected %s actual %s", $time,
                        want.status.name(), rsp_data.status.name());
               error_count++;
            end
         end
      end
   end

   initial begin
      error_count  = 0;
      steady_items = 0;
      reset        = 1'b1;
      start        = 1'b0;
      req_data     = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_add_sub();
      test_multiply();
      test_divide();
      test_random();

      // Drop start, drain the pipe, then watch for stray results.
      start <= 1'b0;
      wait (complex_answers.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (error_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   // Hard stop well past the slowest legal run.
   initial begin
      #5000000;
      $display("TEST FAILED");
      $finish;
   end

endmodule
